// ===== rtl/sst_pkg.sv =====
//------------------------------------------------------------------------------
// sst_pkg
// Shared widths, status codes and constants for the sparse triplet store.
//------------------------------------------------------------------------------
package sst_pkg;

	localparam int CAPACITY    = 64;
	localparam int MAX_DIM     = 1024;
	localparam int VALUE_WIDTH = 32;

	localparam int IDX_W   = 10;
	localparam int DIM_W   = 11;
	localparam int ST_W    = 3;
	localparam int TOT_W   = 7;
	localparam int OVAL_W  = 32;
	localparam int ADDR_W  = 1;

	typedef enum logic [ST_W-1:0] {
		ST_OK     = 3'd0,
		ST_BADLOC = 3'd1,
		ST_FULL   = 3'd2,
		ST_ENTRY  = 3'd3,
		ST_EMPTY  = 3'd4
	} status_t;

	localparam logic [ADDR_W-1:0] REG_NUM_ROWS = 1'd0;
	localparam logic [ADDR_W-1:0] REG_NUM_COLS = 1'd1;

	localparam logic [DIM_W-1:0] DIM_RESET = 11'd1024;

endpackage

// ===== rtl/sst_if.sv =====
//------------------------------------------------------------------------------
// sst_if
// Stream channels: input items, result items and configuration writes.
//------------------------------------------------------------------------------
interface sst_in_if;
	logic                        valid;
	logic                        ready;
	logic                        command;
	logic [sst_pkg::IDX_W-1:0]   row_index;
	logic [sst_pkg::IDX_W-1:0]   col_index;
	logic signed [31:0]          new_value;
	modport source (output valid, command, row_index, col_index, new_value, input ready);
	modport sink   (input valid, command, row_index, col_index, new_value, output ready);
endinterface

interface sst_out_if;
	logic                        valid;
	logic                        ready;
	logic [sst_pkg::ST_W-1:0]    status;
	logic [sst_pkg::IDX_W-1:0]   out_row;
	logic [sst_pkg::IDX_W-1:0]   out_col;
	logic signed [31:0]          out_value;
	logic [sst_pkg::TOT_W-1:0]   entry_total;
	logic                        last;
	modport source (output valid, status, out_row, out_col, out_value, entry_total, last,
		input ready);
	modport sink   (input valid, status, out_row, out_col, out_value, entry_total, last,
		output ready);
endinterface

interface sst_cfg_if;
	logic                        valid;
	logic                        ready;
	logic [sst_pkg::ADDR_W-1:0]  index;
	logic [31:0]                 data;
	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/sst_mem.sv =====
//------------------------------------------------------------------------------
// sst_mem
// Entry memory: one write port, one read port, registered read data.
//------------------------------------------------------------------------------
module sst_mem #(
	parameter int DEPTH = sst_pkg::CAPACITY,
	parameter int AW    = 6,
	parameter int DW    = 52
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [DW-1:0] wdata,
	input  logic [AW-1:0] raddr,
	output logic [DW-1:0] rdata
);
	logic [DW-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

// ===== rtl/sparse_triplet_store_transpose.sv =====
//------------------------------------------------------------------------------
// sparse_triplet_store_transpose
// Sorted (row, col, value) store with insert/update/delete and transposed dump.
//------------------------------------------------------------------------------
// One item at a time. Entries live in a single-port-read memory walked by a
// sequencer. Modify: a search pass over the entries, then shifting each moved
// entry with a read state and a write state. Transpose: one column-minimum scan
// of the entries per emitted beat. No clearing pass after reset.
module sparse_triplet_store_transpose #(
	parameter int CAPACITY    = sst_pkg::CAPACITY,
	parameter int VALUE_WIDTH = sst_pkg::VALUE_WIDTH,
	parameter int MAX_DIM     = sst_pkg::MAX_DIM
) (
	input  logic clk,
	input  logic arst_n,
	sst_in_if.sink   in_ch,
	sst_out_if.source out_ch,
	sst_cfg_if.sink  cfg
);
	localparam int AW  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CW  = $clog2(CAPACITY + 1);
	localparam int IW  = sst_pkg::IDX_W;
	localparam int DW  = 2 * IW + VALUE_WIDTH;
	localparam int MW  = ($clog2(MAX_DIM + 1) > 11) ? $clog2(MAX_DIM + 1) : 11;
	localparam logic [MW-1:0] MAXD = MW'(MAX_DIM);

	typedef enum logic [8:0] {
		S_IDLE  = 9'b000000001,
		S_SRCH  = 9'b000000010,
		S_DEC   = 9'b000000100,
		S_SHR   = 9'b000001000,
		S_SHW   = 9'b000010000,
		S_TSCAN = 9'b000100000,
		S_TEMIT = 9'b001000000,
		S_OUT   = 9'b010000000,
		S_WAIT  = 9'b100000000
	} state_t;

	state_t state_q;
	logic [sst_pkg::DIM_W-1:0] rows_q, cols_q;
	logic [CW-1:0] count_q, ptr_q, rd_q, pos_q, emitted_q;
	logic          rvalid_q;
	logic [IW-1:0] row_q, col_q;
	logic [VALUE_WIDTH-1:0] val_q;
	logic          found_q, ins_q;
	logic [DW-1:0] hold_q;
	// transpose scan: last emitted key (col, entry index) and best candidate
	logic          have_prev_q, have_best_q;
	logic [IW-1:0] pcol_q;
	logic [CW-1:0] pidx_q, bidx_q;
	logic [IW-1:0] bcol_q, brow_q;
	logic [VALUE_WIDTH-1:0] bval_q;

	logic          ovalid_q, olast_q;
	logic [sst_pkg::ST_W-1:0] ost_q;
	logic [IW-1:0] orow_q, ocol_q;
	logic [VALUE_WIDTH-1:0] oval_q;
	logic [CW-1:0] otot_q;

	logic          we;
	logic [AW-1:0] waddr, raddr;
	logic [DW-1:0] wdata, rdata;
	logic [IW-1:0] m_row, m_col;
	logic [VALUE_WIDTH-1:0] m_val;
	logic [CW-1:0] ridx;

	sst_mem #(.DEPTH(CAPACITY), .AW(AW), .DW(DW)) u_mem (
		.clk, .we, .waddr, .wdata, .raddr, .rdata
	);

	assign m_row = rdata[DW-1 -: IW];
	assign m_col = rdata[VALUE_WIDTH +: IW];
	assign m_val = rdata[VALUE_WIDTH-1:0];
	assign ridx  = rd_q - CW'(1);

	assign cfg.ready   = 1'b1;
	assign in_ch.ready = (state_q == S_IDLE);

	assign out_ch.valid       = ovalid_q;
	assign out_ch.status      = ost_q;
	assign out_ch.out_row     = orow_q;
	assign out_ch.out_col     = ocol_q;
	assign out_ch.out_value   = 32'(oval_q);
	assign out_ch.entry_total = sst_pkg::TOT_W'(otot_q);
	assign out_ch.last        = olast_q;

	logic better;
	always_comb begin
		logic after_prev;
		after_prev = !have_prev_q || (m_col > pcol_q) ||
			(m_col == pcol_q && ridx > pidx_q);
		better = after_prev && (!have_best_q || m_col < bcol_q);
	end

	logic key_lt;
	assign key_lt = (m_row < row_q) || (m_row == row_q && m_col < col_q);

	always_comb begin
		raddr = AW'(rd_q);
		we    = 1'b0;
		waddr = AW'(pos_q);
		wdata = hold_q;
		case (state_q)
			S_DEC: begin
				if (found_q && val_q != '0) begin
					we = 1'b1;
					wdata = {row_q, col_q, val_q};
				end
			end
			S_SHW: begin
				we = !rvalid_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			rows_q   <= sst_pkg::DIM_RESET;
			cols_q   <= sst_pkg::DIM_RESET;
			count_q  <= '0;
			ovalid_q <= 1'b0;
		end else begin
			if (cfg.valid) begin
				if (cfg.index == sst_pkg::REG_NUM_ROWS) rows_q <= cfg.data[10:0];
				else rows_q <= rows_q;
				if (cfg.index == sst_pkg::REG_NUM_COLS) cols_q <= cfg.data[10:0];
			end
			if (ovalid_q && out_ch.ready) ovalid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (in_ch.valid) begin
						row_q <= in_ch.row_index;
						col_q <= in_ch.col_index;
						val_q <= VALUE_WIDTH'(unsigned'(in_ch.new_value));
						rd_q <= '0;
						rvalid_q <= 1'b0;
						pos_q <= count_q;
						found_q <= 1'b0;
						have_prev_q <= 1'b0;
						have_best_q <= 1'b0;
						emitted_q <= '0;
						orow_q <= '0; ocol_q <= '0; oval_q <= '0;
						olast_q <= 1'b1;
						if (in_ch.command) begin
							if (count_q == '0) begin
								ost_q <= sst_pkg::ST_EMPTY;
								otot_q <= count_q;
								state_q <= S_OUT;
							end else begin
								state_q <= S_TSCAN;
							end
						end else if ({1'b0, in_ch.row_index} >= rows_q ||
							{1'b0, in_ch.col_index} >= cols_q ||
							MW'(in_ch.row_index) >= MAXD || MW'(in_ch.col_index) >= MAXD) begin
							ost_q <= sst_pkg::ST_BADLOC;
							otot_q <= count_q;
							state_q <= S_OUT;
						end else begin
							state_q <= S_SRCH;
						end
					end
				end
				S_SRCH: begin
					// stream reads; first entry not below key sets pos
					rvalid_q <= (rd_q < count_q);
					rd_q <= rd_q + CW'(1);
					if (rvalid_q && !key_lt) begin
						pos_q <= ridx;
						found_q <= (m_row == row_q && m_col == col_q);
						state_q <= S_DEC;
					end else if (rd_q >= count_q && !(rd_q == count_q && !rvalid_q
						&& count_q != '0)) begin
						if (!rvalid_q || rd_q > count_q) state_q <= S_DEC;
					end
				end
				S_DEC: begin
					ost_q <= sst_pkg::ST_OK;
					if (found_q) begin
						if (val_q == '0) begin
							// delete: pull entries down from pos+1
							ins_q <= 1'b0;
							rd_q <= pos_q + CW'(1);
							count_q <= count_q - CW'(1);
							otot_q <= count_q - CW'(1);
							if (pos_q + CW'(1) >= count_q) state_q <= S_OUT;
							else state_q <= S_SHR;
						end else begin
							otot_q <= count_q;
							state_q <= S_OUT;
						end
					end else if (val_q == '0) begin
						otot_q <= count_q;
						state_q <= S_OUT;
					end else if (count_q >= CW'(CAPACITY)) begin
						ost_q <= sst_pkg::ST_FULL;
						otot_q <= count_q;
						state_q <= S_OUT;
					end else begin
						// insert: move entries up from the top, then write key
						ins_q <= 1'b1;
						rd_q <= count_q - CW'(1);
						bidx_q <= pos_q;
						count_q <= count_q + CW'(1);
						otot_q <= count_q + CW'(1);
						if (count_q == pos_q) begin
							hold_q <= {row_q, col_q, val_q};
							state_q <= S_SHW;
						end else begin
							state_q <= S_SHR;
						end
					end
				end
				S_SHR: begin
					state_q <= S_SHW;
					rvalid_q <= 1'b1;
				end
				S_SHW: begin
					if (rvalid_q) begin
						hold_q <= rdata;
						rvalid_q <= 1'b0;
						pos_q <= ins_q ? rd_q + CW'(1) : rd_q - CW'(1);
						state_q <= S_SHW;
					end
					if (!rvalid_q) begin
						if (ins_q) begin
							if (pos_q == bidx_q) begin
								state_q <= S_OUT;
							end else if (rd_q == bidx_q) begin
								hold_q <= {row_q, col_q, val_q};
								pos_q <= bidx_q;
								rd_q <= bidx_q;
								rvalid_q <= 1'b0;
							end else begin
								rd_q <= rd_q - CW'(1);
								state_q <= S_SHR;
							end
						end else begin
							if (rd_q + CW'(1) >= count_q + CW'(1)) state_q <= S_OUT;
							else begin
								rd_q <= rd_q + CW'(1);
								state_q <= S_SHR;
							end
						end
					end
				end
				S_TSCAN: begin
					rvalid_q <= (rd_q < count_q);
					rd_q <= rd_q + CW'(1);
					if (rvalid_q && better) begin
						have_best_q <= 1'b1;
						bidx_q <= ridx;
						bcol_q <= m_col;
						brow_q <= m_row;
						bval_q <= m_val;
					end
					if (!rvalid_q && rd_q != '0) state_q <= S_TEMIT;
				end
				S_TEMIT: begin
					if (!ovalid_q) begin
						ovalid_q <= 1'b1;
						ost_q <= sst_pkg::ST_ENTRY;
						orow_q <= bcol_q;
						ocol_q <= brow_q;
						oval_q <= bval_q;
						otot_q <= count_q;
						olast_q <= (emitted_q + CW'(1) == count_q);
						emitted_q <= emitted_q + CW'(1);
						have_prev_q <= 1'b1;
						pcol_q <= bcol_q;
						pidx_q <= bidx_q;
						have_best_q <= 1'b0;
						rd_q <= '0;
						rvalid_q <= 1'b0;
						state_q <= (emitted_q + CW'(1) == count_q) ? S_WAIT : S_TSCAN;
					end
				end
				S_OUT: begin
					if (!ovalid_q) begin
						ovalid_q <= 1'b1;
						state_q <= S_WAIT;
					end
				end
				S_WAIT: begin
					if (!ovalid_q || out_ch.ready) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule
